[src/scb_pkg.sv]
// ----------------------------------------------------------------------------
// scb_pkg: shared types and constants of the scaled color-key blitter
// Request and result payloads, request kinds, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none
package scb_pkg;

  // request kinds
  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_DRAW = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_KEY   = 3'd6;

  // register reset values
  localparam logic [12:0] TEX_WIDTH_RST   = 13'd64;
  localparam logic [14:0] FRAME_WIDTH_RST = 15'd128;
  localparam logic [14:0] CLIP_SIZE_RST   = 15'd128;
  localparam logic [31:0] COLOR_KEY_RST   = 32'hffff00ff;

  // saturation limit of the pixel count
  localparam logic [14:0] COUNT_MAX = 15'h7fff;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] texel_addr;
    logic [31:0] texel_value;
    logic [13:0] frame_addr;
    logic [11:0] src_x;
    logic [11:0] src_y;
    logic [11:0] src_width;
    logic [11:0] src_height;
    logic [11:0] dst_x;
    logic [11:0] dst_y;
    logic [10:0] dst_width;
    logic [10:0] dst_height;
  } scb_req_t;

  typedef struct packed {
    logic [31:0] read_pixel;
    logic        status;
    logic [14:0] pixels_written;
  } scb_rsp_t;

endpackage
`default_nettype wire

[src/scaled_colorkey_sprite_blitter.sv]
// ----------------------------------------------------------------------------
// scaled_colorkey_sprite_blitter: 2D blitter with clipping, scaling, color key
// Draws: the divider forms both scale ratios, then the clipped area is walked
//   at one pixel per cycle on the texture read port, with a setup state
//   (ST_LINE) before each line; empty draws answer from the clip step.
// Throughput: one request at a time.
// Reset: registers take their defaults; the frame memory is zeroed by a
//   clearing pass, during which no request is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module scaled_colorkey_sprite_blitter #(
  parameter int unsigned TEX_PIXELS   = 4096,
  parameter int unsigned FRAME_PIXELS = 16384,
  parameter int unsigned FRAC_BITS    = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [2:0]        cfg_idx_i,
  input  wire logic [31:0]       cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire scb_pkg::scb_req_t in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output scb_pkg::scb_rsp_t      out_rsp_o
);
  import scb_pkg::*;

  localparam int unsigned TAW = $clog2(TEX_PIXELS);
  localparam int unsigned FAW = $clog2(FRAME_PIXELS);
  localparam int unsigned QW  = 12 + FRAC_BITS;
  localparam int unsigned AW  = FRAC_BITS + TAW;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_CLIP, ST_DIVX, ST_DIVY,
    ST_MUL, ST_START, ST_LINE, ST_PIX, ST_DRAIN
  } state_e;

  state_e state_q;

  // configuration
  logic [12:0] tex_w_q;
  logic [14:0] frame_w_q, clip_w_q, clip_h_q;
  logic [13:0] clip_x_q, clip_y_q;
  logic [31:0] key_q;

  // request and draw state
  scb_req_t    req_q;
  logic [FAW-1:0] clr_q;
  logic [10:0] dw_q, dh_q, off_x_q, off_y_q, x_q, y_q;
  logic [13:0] dx0_q, dy0_q;
  logic        same_q;
  logic [QW-1:0] ratio_x_q, ratio_y_q;
  logic [AW-1:0] prod_x_q, prod_y_q, start_x_q, acc_x_q, acc_y_q;
  logic [TAW-1:0] row_base_q;
  logic [FAW-1:0] fbase_q, cur_y_q;
  logic        p_valid_q;
  logic [FAW-1:0] p_faddr_q;
  logic [14:0] cnt_q;

  // output register
  logic        out_valid_q;
  scb_rsp_t    out_q;

  logic in_acc;
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  // clip computation from the held request
  logic signed [17:0] tx, ty, cx, cy, dx0, dy0, ex, ey, ecx, ecy, dw, dh;
  logic               empty;
  always_comb begin
    tx  = {{6{req_q.dst_x[11]}}, req_q.dst_x};
    ty  = {{6{req_q.dst_y[11]}}, req_q.dst_y};
    cx  = {4'b0, clip_x_q};
    cy  = {4'b0, clip_y_q};
    dx0 = (tx > cx) ? tx : cx;
    dy0 = (ty > cy) ? ty : cy;
    ex  = tx + {7'b0, req_q.dst_width};
    ey  = ty + {7'b0, req_q.dst_height};
    ecx = cx + {3'b0, clip_w_q};
    ecy = cy + {3'b0, clip_h_q};
    dw  = ((ex < ecx) ? ex : ecx) - dx0;
    dh  = ((ey < ecy) ? ey : ecy) - dy0;
    empty = (clip_w_q == '0) || (clip_h_q == '0) || (dw <= 0) || (dh <= 0);
  end

  // shared divider: width ratio first, then height ratio
  logic          div_start, div_done;
  logic [QW-1:0] div_quo, div_num;
  logic [10:0]   div_den;
  assign div_start = ((state_q == ST_CLIP) && !empty) || ((state_q == ST_DIVX) && div_done);
  assign div_num   = (state_q == ST_CLIP) ? {req_q.src_width, {FRAC_BITS{1'b0}}}
                                          : {req_q.src_height, {FRAC_BITS{1'b0}}};
  assign div_den   = (state_q == ST_CLIP) ? req_q.dst_width : req_q.dst_height;

  scb_div #(.NW(QW), .DW(11)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // memories
  logic           tex_we;
  logic [TAW-1:0] tex_raddr;
  logic [31:0]    tex_rdata;
  logic           fr_we;
  logic [FAW-1:0] fr_waddr, fr_raddr;
  logic [31:0]    fr_wdata, fr_rdata;

  assign tex_we    = in_acc && (in_req_i.kind == KIND_LOAD);
  assign tex_raddr = row_base_q + acc_x_q[FRAC_BITS +: TAW];

  scb_ram #(.WIDTH(32), .DEPTH(TEX_PIXELS)) u_tex_ram (
    .clk_i   (clk_i),
    .we_i    (tex_we),
    .waddr_i (TAW'(in_req_i.texel_addr)),
    .wdata_i (in_req_i.texel_value),
    .raddr_i (tex_raddr),
    .rdata_o (tex_rdata)
  );

  // pixel write stage, or the clearing pass
  logic        pix_wr;
  logic [14:0] cnt_d;
  assign pix_wr   = p_valid_q && (tex_rdata != key_q);
  assign fr_we    = (state_q == ST_CLEAR) || pix_wr;
  assign fr_waddr = (state_q == ST_CLEAR) ? clr_q : p_faddr_q;
  assign fr_wdata = (state_q == ST_CLEAR) ? 32'd0 : tex_rdata;
  assign fr_raddr = FAW'(in_req_i.frame_addr);
  assign cnt_d    = (pix_wr && (cnt_q != COUNT_MAX)) ? cnt_q + 15'd1 : cnt_q;

  scb_ram #(.WIDTH(32), .DEPTH(FRAME_PIXELS)) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .waddr_i (fr_waddr),
    .wdata_i (fr_wdata),
    .raddr_i (fr_raddr),
    .rdata_o (fr_rdata)
  );

  // step products and per-pixel steps
  logic [QW+10:0] mul_x, mul_y;
  logic [AW-1:0]  step_x, step_y;
  assign mul_x  = off_x_q * ratio_x_q;
  assign mul_y  = off_y_q * ratio_y_q;
  assign step_x = same_q ? AW'(2**FRAC_BITS) : AW'(ratio_x_q);
  assign step_y = same_q ? AW'(2**FRAC_BITS) : AW'(ratio_y_q);

  // sequencer, configuration and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      tex_w_q     <= TEX_WIDTH_RST;
      frame_w_q   <= FRAME_WIDTH_RST;
      clip_x_q    <= '0;
      clip_y_q    <= '0;
      clip_w_q    <= CLIP_SIZE_RST;
      clip_h_q    <= CLIP_SIZE_RST;
      key_q       <= COLOR_KEY_RST;
      req_q       <= '0;
      clr_q       <= '0;
      dw_q        <= '0;
      dh_q        <= '0;
      off_x_q     <= '0;
      off_y_q     <= '0;
      x_q         <= '0;
      y_q         <= '0;
      dx0_q       <= '0;
      dy0_q       <= '0;
      same_q      <= 1'b0;
      ratio_x_q   <= '0;
      ratio_y_q   <= '0;
      prod_x_q    <= '0;
      prod_y_q    <= '0;
      start_x_q   <= '0;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      row_base_q  <= '0;
      fbase_q     <= '0;
      cur_y_q     <= '0;
      p_valid_q   <= 1'b0;
      p_faddr_q   <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TEX_WIDTH:   tex_w_q   <= cfg_wdata_i[12:0];
          CFG_FRAME_WIDTH: frame_w_q <= cfg_wdata_i[14:0];
          CFG_CLIP_X:      clip_x_q  <= cfg_wdata_i[13:0];
          CFG_CLIP_Y:      clip_y_q  <= cfg_wdata_i[13:0];
          CFG_CLIP_WIDTH:  clip_w_q  <= cfg_wdata_i[14:0];
          CFG_CLIP_HEIGHT: clip_h_q  <= cfg_wdata_i[14:0];
          CFG_COLOR_KEY:   key_q     <= cfg_wdata_i;
          default: ;
        endcase
      end

      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      cnt_q     <= cnt_d;
      p_valid_q <= 1'b0;

      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == '1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            req_q <= in_req_i;
            out_q <= '0;
            case (in_req_i.kind)
              KIND_DRAW: state_q <= ST_CLIP;
              KIND_READ: state_q <= ST_READ;
              default:   out_valid_q <= 1'b1;
            endcase
          end
        end
        ST_READ: begin
          out_q.read_pixel <= fr_rdata;
          out_valid_q      <= 1'b1;
          state_q          <= ST_IDLE;
        end
        ST_CLIP: begin
          dw_q    <= dw[10:0];
          dh_q    <= dh[10:0];
          dx0_q   <= dx0[13:0];
          dy0_q   <= dy0[13:0];
          off_x_q <= 11'(dx0 - tx);
          off_y_q <= 11'(dy0 - ty);
          same_q  <= (req_q.src_width == {1'b0, dw[10:0]}) &&
                     (req_q.src_height == {1'b0, dh[10:0]});
          cnt_q   <= '0;
          if (empty) begin
            out_q.status <= 1'b1;
            out_valid_q  <= 1'b1;
            state_q      <= ST_IDLE;
          end else begin
            state_q <= ST_DIVX;
          end
        end
        ST_DIVX: begin
          if (div_done) begin
            ratio_x_q <= div_quo;
            state_q   <= ST_DIVY;
          end
        end
        ST_DIVY: begin
          if (div_done) begin
            ratio_y_q <= div_quo;
            state_q   <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_x_q <= AW'(mul_x);
          prod_y_q <= AW'(mul_y);
          state_q  <= ST_START;
        end
        ST_START: begin
          start_x_q <= AW'({req_q.src_x, {FRAC_BITS{1'b0}}}) + prod_x_q;
          acc_y_q   <= AW'({req_q.src_y, {FRAC_BITS{1'b0}}}) + prod_y_q;
          cur_y_q   <= FAW'(dy0_q);
          y_q       <= '0;
          state_q   <= ST_LINE;
        end
        ST_LINE: begin
          row_base_q <= TAW'(acc_y_q[FRAC_BITS +: TAW] * tex_w_q);
          fbase_q    <= FAW'(cur_y_q * frame_w_q + dx0_q);
          acc_x_q    <= start_x_q;
          x_q        <= '0;
          state_q    <= ST_PIX;
        end
        ST_PIX: begin
          p_valid_q <= 1'b1;
          p_faddr_q <= fbase_q + FAW'(x_q);
          acc_x_q   <= acc_x_q + step_x;
          x_q       <= x_q + 11'd1;
          if (x_q == dw_q - 11'd1) begin
            acc_y_q <= acc_y_q + step_y;
            cur_y_q <= cur_y_q + 1'b1;
            y_q     <= y_q + 11'd1;
            state_q <= (y_q == dh_q - 11'd1) ? ST_DRAIN : ST_LINE;
          end
        end
        ST_DRAIN: begin
          out_q.pixels_written <= cnt_d;
          out_q.status         <= (cnt_d == '0);
          out_valid_q          <= 1'b1;
          state_q              <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule
`default_nettype wire

[src/scb_ram.sv]
// ----------------------------------------------------------------------------
// scb_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module scb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

[src/scb_div.sv]
// ----------------------------------------------------------------------------
// scb_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle; done pulses when the last quotient bit is formed.
// ----------------------------------------------------------------------------
`default_nettype none
module scb_div #(
  parameter int unsigned NW = 28,
  parameter int unsigned DW = 11
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  output logic               done_o,
  output logic      [NW-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic [DW-1:0] rem_q, dvs_q;
  logic [NW-1:0] quo_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [DW:0]   trial;
  logic          fits;

  // shift in the next dividend bit and try a subtract
  assign trial = {rem_q, quo_q[NW-1]};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      dvs_q  <= '0;
      quo_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= '0;
        dvs_q  <= divisor_i;
        quo_q  <= dividend_i;
        cnt_q  <= CW'(NW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= fits ? DW'(trial - {1'b0, dvs_q}) : trial[DW-1:0];
        quo_q <= {quo_q[NW-2:0], fits};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

[sim/scaled_colorkey_sprite_blitter_tb.sv]
// ----------------------------------------------------------------------------
// scaled_colorkey_sprite_blitter_tb: self-checking bench of the sprite blitter
// Fills the texture, then sends loads, draws and pixel reads under several
// register settings and random idling on both sides. A frame/texture shadow
// predicts every response, and a scoreboard compares them in order.
// ----------------------------------------------------------------------------
`default_nettype none
module scaled_colorkey_sprite_blitter_tb;
  import scb_pkg::*;

  localparam int unsigned TEX_N   = 4096;
  localparam int unsigned FRAME_N = 16384;
  localparam int unsigned FRAC    = 16;
  localparam int unsigned N_RAND  = 1250;
  localparam int unsigned REQ_W   = $bits(scb_req_t);
  localparam logic [1:0]  KIND_BAD = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  scb_req_t    in_req_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  scb_rsp_t    out_rsp_o;

  int unsigned errors = 0;
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  bit          hold_go = 1'b0;
  logic [31:0] palette [4] = '{32'hffff00ff, 32'h0, 32'hffffffff, 32'h80402010};

  scaled_colorkey_sprite_blitter u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .in_req_i,
    .out_valid_o, .out_stall_i, .out_rsp_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic report(input string msg);
    errors++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // shadow of the blitter state and the response order
  class blit_scoreboard;
    logic [31:0] tex [TEX_N];
    logic [31:0] frame [FRAME_N];
    longint      tex_w, frame_w, clip_x, clip_y, clip_w, clip_h;
    logic [31:0] key;
    scb_rsp_t    expected_rsps [$];
    int unsigned n_load, n_draw, n_read, n_empty, n_pix;

    function new();
      foreach (frame[i]) frame[i] = '0;
      foreach (tex[i]) tex[i] = '0;
      tex_w = 64; frame_w = 128; clip_x = 0; clip_y = 0;
      clip_w = 128; clip_h = 128; key = 32'hffff00ff;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        CFG_TEX_WIDTH:   tex_w = longint'(v[12:0]);
        CFG_FRAME_WIDTH: frame_w = longint'(v[14:0]);
        CFG_CLIP_X:      clip_x = longint'(v[13:0]);
        CFG_CLIP_Y:      clip_y = longint'(v[13:0]);
        CFG_CLIP_WIDTH:  clip_w = longint'(v[14:0]);
        CFG_CLIP_HEIGHT: clip_h = longint'(v[14:0]);
        CFG_COLOR_KEY:   key = v;
        default: ;
      endcase
    endfunction

    // clip, then walk the overlap in 16.16 fixed point
    function longint blit(scb_req_t r);
      longint tx0, ty0, tw, th, dx0, dy0, dw, dh, rx, ry, stx, sty, row, col, cnt;
      bit same;
      tx0 = longint'($signed(r.dst_x));
      ty0 = longint'($signed(r.dst_y));
      tw = longint'(r.dst_width);
      th = longint'(r.dst_height);
      cnt = 0;
      if (clip_w == 0 || clip_h == 0) return 0;
      dx0 = (tx0 > clip_x) ? tx0 : clip_x;
      dy0 = (ty0 > clip_y) ? ty0 : clip_y;
      dw = ((tx0 + tw < clip_x + clip_w) ? tx0 + tw : clip_x + clip_w) - dx0;
      dh = ((ty0 + th < clip_y + clip_h) ? ty0 + th : clip_y + clip_h) - dy0;
      if (dw <= 0 || dh <= 0) return 0;
      rx = (longint'(r.src_width) << FRAC) / tw;
      ry = (longint'(r.src_height) << FRAC) / th;
      stx = (longint'(r.src_x) << FRAC) + (dx0 - tx0) * rx;
      sty = (longint'(r.src_y) << FRAC) + (dy0 - ty0) * ry;
      same = (longint'(r.src_width) == dw) && (longint'(r.src_height) == dh);
      for (longint y = 0; y < dh; y++) begin
        row = same ? (sty >> FRAC) + y : (sty + y * ry) >> FRAC;
        for (longint x = 0; x < dw; x++) begin
          col = same ? (stx >> FRAC) + x : (stx + x * rx) >> FRAC;
          if (tex[(row * tex_w + col) % TEX_N] != key) begin
            frame[((dy0 + y) * frame_w + dx0 + x) % FRAME_N] =
              tex[(row * tex_w + col) % TEX_N];
            cnt++;
          end
        end
      end
      return cnt;
    endfunction

    function void note_request(scb_req_t r);
      scb_rsp_t e;
      longint   n;
      e = '0;
      case (r.kind)
        KIND_LOAD: begin
          tex[r.texel_addr] = r.texel_value;
          n_load++;
        end
        KIND_DRAW: begin
          n = blit(r);
          e.status = (n == 0);
          e.pixels_written = (n > COUNT_MAX) ? COUNT_MAX : n[14:0];
          n_draw++;
          if (n == 0) n_empty++;
          n_pix += 32'(n);
        end
        KIND_READ: begin
          e.read_pixel = frame[r.frame_addr];
          n_read++;
        end
        default: ;
      endcase
      expected_rsps.push_back(e);
    endfunction

    task check_result(scb_rsp_t got);
      scb_rsp_t e;
      if (expected_rsps.size() == 0) begin
        report($sformatf("unexpected response %h", got));
        return;
      end
      e = expected_rsps.pop_front();
      if (got.read_pixel !== e.read_pixel)
        report($sformatf("read_pixel %h, want %h", got.read_pixel, e.read_pixel));
      if (got.status !== e.status)
        report($sformatf("status %b, want %b", got.status, e.status));
      if (got.pixels_written !== e.pixels_written)
        report($sformatf("pixels_written %0d, want %0d",
                         got.pixels_written, e.pixels_written));
    endtask
  endclass

  blit_scoreboard sb = new();

  // request side: idle gaps lower valid, a held request stays up
  task automatic send_req(input scb_req_t r);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(r);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_rsps.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // register write, then the write enable is lowered again
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    sb.set_reg(idx, v);
  endtask

  task automatic set_regs(input logic [31:0] tw, fw, cx, cy, cw, ch, k);
    write_reg(CFG_TEX_WIDTH, tw);
    write_reg(CFG_FRAME_WIDTH, fw);
    write_reg(CFG_CLIP_X, cx);
    write_reg(CFG_CLIP_Y, cy);
    write_reg(CFG_CLIP_WIDTH, cw);
    write_reg(CFG_CLIP_HEIGHT, ch);
    write_reg(CFG_COLOR_KEY, k);
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] texel_val();
    return ($urandom_range(99) < 20) ? palette[$urandom_range(3)] : $urandom;
  endfunction

  function automatic scb_req_t make_draw(int sx, int sy, int sw, int sh,
                                         int dx, int dy, int dw, int dh);
    scb_req_t r;
    r = '0;
    r.kind = KIND_DRAW;
    r.src_x = 12'(sx); r.src_y = 12'(sy); r.src_width = 12'(sw); r.src_height = 12'(sh);
    r.dst_x = 12'(dx); r.dst_y = 12'(dy); r.dst_width = 11'(dw); r.dst_height = 11'(dh);
    return r;
  endfunction

  // mostly sprites near the clip window, some raw noise
  function automatic scb_req_t rand_req();
    scb_req_t r;
    int unsigned p;
    int dw, dh;
    r = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
    p = $urandom_range(99);
    if (p < 20) r.kind = KIND_LOAD;
    else if (p < 65) r.kind = KIND_DRAW;
    else if (p < 95) r.kind = KIND_READ;
    else r.kind = KIND_BAD;
    if (r.kind == KIND_LOAD) r.texel_value = texel_val();
    if (r.kind == KIND_DRAW) begin
      if ($urandom_range(99) < 80) begin
        dw = $urandom_range(24);
        dh = $urandom_range(24);
        r.dst_x = 12'(int'(sb.clip_x < 2000 ? sb.clip_x : 2000) - 10 +
                      int'($urandom_range(150)));
        r.dst_y = 12'(int'(sb.clip_y < 2000 ? sb.clip_y : 2000) - 10 +
                      int'($urandom_range(150)));
        r.dst_width = 11'(dw);
        r.dst_height = 11'(dh);
        p = $urandom_range(99);
        if (p < 40) begin
          r.src_width = 12'(dw);
          r.src_height = 12'(dh);
        end else if (p < 90) begin
          r.src_width = 12'($urandom_range(40));
          r.src_height = 12'($urandom_range(40));
        end
      end else if (sb.clip_w * sb.clip_h > 4096) begin
        r.dst_width = 11'($urandom_range(63));
        r.dst_height = 11'($urandom_range(63));
      end
    end
    return r;
  endfunction

  // long receiver hold-off, timed on its own
  initial begin
    wait (hold_go);
    repeat (3000) @(posedge clk_i);
    hold_go = 1'b0;
  end

  // response side: check accepted responses, stall at random
  initial begin
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_rsp_o);
      out_stall_i <= hold_go || ($urandom_range(99) < recv_idle);
    end
  end

  initial begin
    #(200_000_000);
    $display("scaled_colorkey_sprite_blitter_tb: errors");
    $finish;
  end

  initial begin
    scb_req_t r;
    int unsigned seg;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // texture fill so that no draw touches an unwritten texel
    for (int i = 0; i < TEX_N; i++) begin
      r = '0;
      r.kind = KIND_LOAD;
      r.texel_addr = 12'(i);
      r.texel_value = texel_val();
      if (i == 0 || i == 1 || i == 64 || i == 65) r.texel_value = 32'hffff00ff;
      if (i == TEX_N - 1) r.texel_value = 32'hffffffff;
      send_req(r);
    end

    // directed cases
    r = '0; r.kind = KIND_LOAD; r.texel_addr = 12'd4095; r.texel_value = 32'h0;
    send_req(r);
    r = '0; r.kind = KIND_READ; r.frame_addr = 14'd0;
    send_req(r);
    r.frame_addr = 14'h3fff;
    send_req(r);
    r = '0; r.kind = KIND_BAD; r.frame_addr = 14'h3fff;
    send_req(r);
    send_req(make_draw(0, 0, 2, 2, 5, 5, 2, 2));             // all keyed
    send_req(make_draw(0, 0, 16, 16, 3, 4, 16, 16));         // one to one
    send_req(make_draw(8, 8, 4, 4, 20, 20, 16, 16));         // scale up
    send_req(make_draw(0, 0, 40, 30, 40, 40, 10, 7));        // scale down
    send_req(make_draw(4095, 4095, 4095, 4095, 120, 120, 12, 12));
    send_req(make_draw(0, 0, 5, 5, -2048, -2048, 2047, 2047)); // empty overlap
    send_req(make_draw(0, 0, 5, 5, 2047, 2047, 2047, 2047));   // off the clip
    send_req(make_draw(0, 0, 0, 0, 10, 10, 0, 0));             // zero size
    send_req(make_draw(1, 2, 3, 3, -5, -6, 10, 12));           // clipped corner
    r = '0; r.kind = KIND_READ; r.frame_addr = 14'(5 * 128 + 5);
    send_req(r);
    r.frame_addr = 14'(20 * 128 + 21);
    send_req(r);
    wait_idle();
    set_regs(64, 128, 0, 0, 300, 300, 32'h0badf00d);
    send_req(make_draw(0, 0, 255, 255, 0, 0, 255, 255));       // count saturates
    send_req(make_draw(0, 0, 300, 300, -1000, -1000, 2047, 2047));
    r = '0; r.kind = KIND_READ; r.frame_addr = 14'd77;
    send_req(r);
    wait_idle();

    // random phases, one register setting per segment
    for (int i = 0; i < N_RAND; i++) begin
      if (i == 0)   begin send_idle = 25; recv_idle = 65; end
      if (i == 416) begin send_idle = 65; recv_idle = 25; end
      if (i == 832) begin send_idle = 0;  recv_idle = 0;  end
      if (i == 100) hold_go = 1'b1;
      if (i % 156 == 0) begin
        seg = i / 156;
        wait_idle();
        case (seg)
          0: set_regs(64, 128, 0, 0, 128, 128, 32'hffff00ff);
          1: set_regs(0, 1, 0, 0, 16384, 16384, palette[1]);
          2: set_regs(4096, 16384, 16383, 16383, 16384, 16384, palette[2]);
          3: set_regs(64, 128, 0, 0, 0, 128, palette[0]);
          4: set_regs(13, 100, 5, 7, 60, 40, palette[3]);
          5: set_regs(1, 0, 0, 0, 64, 64, 32'h0);
          6: set_regs(64, 128, 10, 10, 100, 90, palette[0]);
          default: set_regs(4095, 16383, 0, 0, 128, 0, $urandom);
        endcase
        if (seg == 7) write_reg(CFG_CLIP_HEIGHT, 128);
      end
      send_req(rand_req());
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_rsps.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("covered %0d loads, %0d draws (%0d empty, %0d pixels), %0d reads",
             sb.n_load, sb.n_draw, sb.n_empty, sb.n_pix, sb.n_read);
    $display("across 9 register settings, idling on both sides and a long hold-off");
    if (errors == 0) begin
      $display("scaled_colorkey_sprite_blitter_tb: clean");
    end else begin
      $display("scaled_colorkey_sprite_blitter_tb: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

[sim.f]
src/scb_pkg.sv
src/scb_ram.sv
src/scb_div.sv
src/scaled_colorkey_sprite_blitter.sv
sim/scaled_colorkey_sprite_blitter_tb.sv
